// ----- rtl/button_gesture_detector_defines.svh -----
// ----------------------------------------------------------------------------
// Button gesture detector assertion macros
// Shared concurrent assertion forms for the detector modules.
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_DETECTOR_DEFINES_SVH
`define BUTTON_GESTURE_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BGD_ASSERT_IMPL(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("button gesture detector: assertion failed");

// Next-cycle implication, disabled during reset.
`define BGD_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("button gesture detector: assertion failed");

`endif

// ----- rtl/bgd_pkg.sv -----
// ----------------------------------------------------------------------------
// Button gesture detector package
// Widths, register indexes, event codes and shared structs.
// ----------------------------------------------------------------------------
package bgd_pkg;

   localparam int TIME_BITS  = 32;
   localparam int CFG_W      = 16;
   localparam int CLICK_W    = 8;
   localparam int HOLD_W     = 16;
   localparam int CODE_W     = 3;
   localparam int COUNT_W    = 16;
   localparam int MAX_EVENTS = 3;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_TICKS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_TICKS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLICK_GAP_TICKS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_TICKS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_HOLD_TICKS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LEVEL     = 3'd5;

   localparam logic [CFG_W-1:0] RST_FILTER_TICKS     = 16'd20;
   localparam logic [CFG_W-1:0] RST_DEBOUNCE_TICKS   = 16'd20;
   localparam logic [CFG_W-1:0] RST_CLICK_GAP_TICKS  = 16'd300;
   localparam logic [CFG_W-1:0] RST_LONG_PRESS_TICKS = 16'd1000;
   localparam logic [CFG_W-1:0] RST_LONG_HOLD_TICKS  = 16'd200;
   localparam logic             RST_ACTIVE_LEVEL     = 1'b0;

   typedef enum logic [CODE_W-1:0] {
      EV_PRESS    = 3'd0,
      EV_RELEASE  = 3'd1,
      EV_CLICK    = 3'd2,
      EV_DOUBLE   = 3'd3,
      EV_MULTI    = 3'd4,
      EV_LSTART   = 3'd5,
      EV_LHOLD    = 3'd6,
      EV_LRELEASE = 3'd7
   } event_code_type;

   typedef struct packed {
      logic [CFG_W-1:0] filter_ticks;
      logic [CFG_W-1:0] debounce_ticks;
      logic [CFG_W-1:0] click_gap_ticks;
      logic [CFG_W-1:0] long_press_ticks;
      logic [CFG_W-1:0] long_hold_ticks;
      logic             active_level;
   } cfg_type;

   typedef struct packed {
      event_code_type     code;
      logic [COUNT_W-1:0] count;
   } event_type;

   // Events of one tick, handed from the engine to the event queue.
   typedef struct packed {
      logic                  load;
      logic [1:0]            total;
      event_type [MAX_EVENTS-1:0] slot;
   } bundle_type;

endpackage

// ----- rtl/bgd_if.sv -----
// ----------------------------------------------------------------------------
// Button gesture detector channels
// Valid/ready interfaces for the tick input and the event output.
// ----------------------------------------------------------------------------
interface bgd_req_if;
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink   (input valid, input pin_level, output ready);
endinterface

interface bgd_rsp_if
   import bgd_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [CODE_W-1:0]  event_code;
   logic [COUNT_W-1:0] event_count;
   logic               last_of_tick;

   modport source (output valid, output event_code, output event_count,
                   output last_of_tick, input ready);
   modport sink   (input valid, input event_code, input event_count,
                   input last_of_tick, output ready);
endinterface

// ----- rtl/bgd_engine.sv -----
// ----------------------------------------------------------------------------
// Button gesture engine
// Registers one tick, runs the glitch filter and gesture machine on it and
// hands the tick's events to the event queue.
// ----------------------------------------------------------------------------
`include "button_gesture_detector_defines.svh"

module bgd_engine
   import bgd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   bgd_req_if.sink    req_bus,
   input  cfg_type    cfg,
   input  logic       queue_free,
   output bundle_type bundle
);

   typedef enum logic [1:0] {
      MODE_IDLE     = 2'd0,
      MODE_PRESSING = 2'd1,
      MODE_LONG     = 2'd2
   } mode_type;

   logic                 in_valid_ff;
   logic                 in_pin_ff;
   logic                 advance;

   logic [TIME_BITS-1:0] time_ff;
   logic [TIME_BITS-1:0] change_start_ff, change_start_in;
   logic [TIME_BITS-1:0] mark_ff, mark_in;
   logic                 primed_ff, primed_in;
   logic                 confirmed_ff, confirmed_in;
   logic                 pending_ff, pending_in;
   mode_type             mode_ff, mode_in;
   logic [CLICK_W-1:0]   click_ff, click_in;
   logic [HOLD_W-1:0]    hold_ff, hold_in;

   logic [TIME_BITS-1:0] filter_age;
   logic [TIME_BITS-1:0] delta;
   logic [TIME_BITS-1:0] elapsed;
   logic                 pressed;
   logic                 edge_hit;
   logic                 mark_hit;
   logic [3:0]           ev_fire;
   event_type [3:0]      ev_data;
   event_type [MAX_EVENTS-1:0] slots;
   logic [1:0]           n_events;

   assign advance       = in_valid_ff && queue_free;
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.valid && req_bus.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_pin_ff <= req_bus.pin_level;
      end
   end

   always_comb begin
      filter_age      = time_ff - change_start_ff;
      delta           = time_ff - mark_ff;
      pressed         = (in_pin_ff == cfg.active_level);
      primed_in       = primed_ff;
      confirmed_in    = confirmed_ff;
      pending_in      = pending_ff;
      change_start_in = change_start_ff;
      mark_in         = mark_ff;
      mode_in         = mode_ff;
      click_in        = click_ff;
      hold_in         = hold_ff;
      edge_hit        = 1'b0;
      mark_hit        = 1'b0;
      elapsed         = delta;
      ev_fire         = '0;
      ev_data         = '0;

      if (!primed_ff) begin
         primed_in    = 1'b1;
         confirmed_in = in_pin_ff;
      end else begin
         // glitch filter
         if (in_pin_ff != confirmed_ff) begin
            if (!pending_ff) begin
               pending_in      = 1'b1;
               change_start_in = time_ff;
            end else if (filter_age >= TIME_BITS'(cfg.filter_ticks)) begin
               confirmed_in = in_pin_ff;
               pending_in   = 1'b0;
               edge_hit     = 1'b1;
            end
         end else begin
            pending_in = 1'b0;
         end

         // confirmed edge
         if (edge_hit) begin
            unique case (mode_ff)
               MODE_PRESSING: begin
                  if (!pressed) begin
                     if (delta >= TIME_BITS'(cfg.debounce_ticks)) begin
                        if (click_ff != '1) begin
                           click_in = click_ff + 1'b1;
                        end
                        ev_fire[0]       = 1'b1;
                        ev_data[0].code  = EV_RELEASE;
                        ev_data[0].count = COUNT_W'(click_in);
                        mark_in          = time_ff;
                        mark_hit         = 1'b1;
                     end
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_LONG: begin
                  if (!pressed) begin
                     mode_in          = MODE_IDLE;
                     mark_in          = time_ff;
                     mark_hit         = 1'b1;
                     ev_fire[0]       = 1'b1;
                     ev_data[0].code  = EV_LRELEASE;
                     ev_data[0].count = '0;
                     hold_in          = '0;
                  end
               end
               default: begin
                  if (pressed) begin
                     mode_in          = MODE_PRESSING;
                     mark_in          = time_ff;
                     mark_hit         = 1'b1;
                     ev_fire[0]       = 1'b1;
                     ev_data[0].code  = EV_PRESS;
                     ev_data[0].count = COUNT_W'(click_ff);
                  end
               end
            endcase
         end

         // timeouts share one elapsed value taken after the edge
         if (mark_hit) begin
            elapsed = '0;
         end

         if (mode_in != MODE_PRESSING && mode_in != MODE_LONG && click_in != '0 &&
             elapsed > TIME_BITS'(cfg.click_gap_ticks)) begin
            ev_fire[1]       = 1'b1;
            ev_data[1].code  = (click_in == CLICK_W'(1)) ? EV_CLICK :
                               (click_in == CLICK_W'(2)) ? EV_DOUBLE : EV_MULTI;
            ev_data[1].count = COUNT_W'(click_in);
            click_in         = '0;
         end

         if (mode_in == MODE_PRESSING && pressed &&
             elapsed > TIME_BITS'(cfg.long_press_ticks)) begin
            mode_in          = MODE_LONG;
            click_in         = '0;
            hold_in          = '0;
            mark_in          = time_ff;
            ev_fire[2]       = 1'b1;
            ev_data[2].code  = EV_LSTART;
            ev_data[2].count = '0;
         end

         if (mode_in == MODE_LONG && pressed &&
             elapsed > TIME_BITS'(cfg.long_hold_ticks)) begin
            if (hold_in != '1) begin
               hold_in = hold_in + 1'b1;
            end
            mark_in          = time_ff;
            ev_fire[3]       = 1'b1;
            ev_data[3].code  = EV_LHOLD;
            ev_data[3].count = COUNT_W'(hold_in);
         end
      end
   end

   // Pack fired events in order into the result slots.
   always_comb begin
      slots    = '0;
      n_events = '0;
      for (int i = 0; i < 4; i++) begin
         if (ev_fire[i] && n_events != 2'd3) begin
            slots[n_events] = ev_data[i];
            n_events        = n_events + 1'b1;
         end
      end
   end

   assign bundle.load  = advance && (n_events != '0);
   assign bundle.total = n_events;
   assign bundle.slot  = slots;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff         <= '0;
         change_start_ff <= '0;
         mark_ff         <= '0;
         primed_ff       <= 1'b0;
         confirmed_ff    <= 1'b0;
         pending_ff      <= 1'b0;
         mode_ff         <= MODE_IDLE;
         click_ff        <= '0;
         hold_ff         <= '0;
      end else if (advance) begin
         time_ff         <= time_ff + 1'b1;
         change_start_ff <= change_start_in;
         mark_ff         <= mark_in;
         primed_ff       <= primed_in;
         confirmed_ff    <= confirmed_in;
         pending_ff      <= pending_in;
         mode_ff         <= mode_in;
         click_ff        <= click_in;
         hold_ff         <= hold_in;
      end
   end

   `BGD_ASSERT_IMPL(a_hold_only_long, clock, reset, hold_ff != '0, mode_ff == MODE_LONG)
   `BGD_ASSERT_IMPL(a_no_clicks_long, clock, reset, mode_ff == MODE_LONG, click_ff == '0)
   `BGD_ASSERT_IMPL(a_pending_primed, clock, reset, pending_ff, primed_ff)

endmodule

// ----- rtl/bgd_event_queue.sv -----
// ----------------------------------------------------------------------------
// Button gesture event queue
// Holds the events of one tick and sends them out one word per cycle while rsp_bus is ready.
// ----------------------------------------------------------------------------
`include "button_gesture_detector_defines.svh"

module bgd_event_queue
   import bgd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  bundle_type bundle,
   output logic       queue_free,
   bgd_rsp_if.source  rsp_bus
);

   event_type [MAX_EVENTS-1:0] slot_ff;
   logic [1:0]                 remaining_ff;
   logic                       take;
   logic                       last_out;

   assign rsp_bus.valid        = (remaining_ff != '0);
   assign rsp_bus.event_code   = slot_ff[0].code;
   assign rsp_bus.event_count  = slot_ff[0].count;
   assign rsp_bus.last_of_tick = (remaining_ff == 2'd1);
   assign take                 = rsp_bus.valid && rsp_bus.ready;
   assign last_out             = take && rsp_bus.last_of_tick && !bundle.load;
   // free once the last held word leaves this cycle
   assign queue_free = (remaining_ff == '0) || ((remaining_ff == 2'd1) && rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
      end else if (bundle.load) begin
         remaining_ff <= bundle.total;
      end else if (take) begin
         remaining_ff <= remaining_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (bundle.load) begin
         slot_ff <= bundle.slot;
      end else if (take) begin
         // advance the next word to the head
         for (int i = 0; i < MAX_EVENTS - 1; i++) begin
            slot_ff[i] <= slot_ff[i+1];
         end
      end
   end

   `BGD_ASSERT_IMPL(a_load_when_free, clock, reset, bundle.load, queue_free)
   `BGD_ASSERT_NEXT(a_drained_after_last, clock, reset, last_out, !rsp_bus.valid)

endmodule

// ----- rtl/button_gesture_detector.sv -----
// ----------------------------------------------------------------------------
// Button gesture detector
// Debounces a sampled button pin and reports press, release, click counts
// and long-press events.
// ----------------------------------------------------------------------------
// Each accepted word on req_bus is one timer tick. A tick is registered and
// then processed, so ticks that cause no event are taken one per cycle
// while the event queue is free. A tick causes up to three events, which
// the event queue sends on rsp_bus one word per cycle while rsp_bus is
// ready, with last_of_tick on the final one; the next tick is processed as
// soon as the queue's last held word leaves.
// Registers are to be written through csr_we/csr_index/csr_wdata only while
// the block is idle, which the block itself does not enforce; writes to an unused index are dropped.
module button_gesture_detector
   import bgd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   bgd_req_if.sink              req_bus,
   bgd_rsp_if.source            rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   cfg_type    cfg_ff;
   bundle_type bundle;
   logic       queue_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_ticks     <= RST_FILTER_TICKS;
         cfg_ff.debounce_ticks   <= RST_DEBOUNCE_TICKS;
         cfg_ff.click_gap_ticks  <= RST_CLICK_GAP_TICKS;
         cfg_ff.long_press_ticks <= RST_LONG_PRESS_TICKS;
         cfg_ff.long_hold_ticks  <= RST_LONG_HOLD_TICKS;
         cfg_ff.active_level     <= RST_ACTIVE_LEVEL;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FILTER_TICKS:     cfg_ff.filter_ticks     <= csr_wdata;
            CSR_DEBOUNCE_TICKS:   cfg_ff.debounce_ticks   <= csr_wdata;
            CSR_CLICK_GAP_TICKS:  cfg_ff.click_gap_ticks  <= csr_wdata;
            CSR_LONG_PRESS_TICKS: cfg_ff.long_press_ticks <= csr_wdata;
            CSR_LONG_HOLD_TICKS:  cfg_ff.long_hold_ticks  <= csr_wdata;
            CSR_ACTIVE_LEVEL:     cfg_ff.active_level     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   bgd_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cfg        (cfg_ff),
      .queue_free (queue_free),
      .bundle     (bundle)
   );

   bgd_event_queue u_event_queue (
      .clock      (clock),
      .reset      (reset),
      .bundle     (bundle),
      .queue_free (queue_free),
      .rsp_bus    (rsp_bus)
   );

endmodule
